### hdl/hsvrgb_pkg.sv
package hsvrgb_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int MID_DEPTH_DEF    = 4;
  localparam int OUT_DEPTH_DEF    = 4;

  localparam int HUE_W = 15;
  localparam int CH_W  = 8;
  localparam int REM_W = 12;

  // One full turn and one 60 degree sector in 1/64 degree units.
  localparam logic [HUE_W-1:0] HUE_TURN   = 15'd23040;
  localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;

  // A sector of 3840 is 15 * 256: the fraction divides by 256, then by 15.
  localparam int FRAC_SHIFT = 8;
  localparam int FRAC_DIV   = 15;

  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  brightness;
  } hsv_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // A classified pixel as it waits between the front and the back.
  typedef struct packed {
    sector_t          sector;
    logic             gray;
    logic [REM_W-1:0] rem;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
  } class_t;

endpackage

### hdl/hsv_to_rgb_converter.sv
// HSV to RGB pixel converter.
// Input side is a queue write port: present a pixel on in_data (hue in
// 1/64 degree steps, saturation, brightness) with push high; it is taken
// at a rising edge where full is low. Results come out of a queue read
// port: while empty is low, out_data holds the oldest red/green/blue
// result, and pop at a rising edge with empty low removes it.
// From the accepting edge a pixel passes the middle queue, the seven back
// stages and the result queue before its result is shown. Throughput is
// one pixel per cycle while the receiver keeps popping: the front
// classifies a pixel into sector and remainder in the accepting cycle and
// writes it to a short queue; the back is a seven-stage arithmetic pipeline
// (fraction by reciprocal, then products and divisions by the channel
// maximum) that feeds the result queue. If the receiver stops popping, the
// result queue fills, the back pipeline freezes with its work intact, the
// middle queue fills and full rises; no pixel is dropped. Synchronous reset
// (rst_n low) empties both queues and invalidates the pipeline; queue storage and pipeline data are not cleared.
module hsv_to_rgb_converter #(
  parameter int CHANNEL_BITS = hsvrgb_pkg::CHANNEL_BITS_DEF,
  parameter int MID_DEPTH    = hsvrgb_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH    = hsvrgb_pkg::OUT_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hsvrgb_pkg::hsv_t in_data,
  output logic             full,
  input  logic             pop,
  output hsvrgb_pkg::rgb_t out_data,
  output logic             empty
);

  hsvrgb_pkg::class_t cls;
  hsvrgb_pkg::class_t mid_item;
  hsvrgb_pkg::rgb_t   res_item;
  logic               mid_empty;
  logic               mid_pop;
  logic               out_full;
  logic               out_push;

  hsvrgb_front #(.CHANNEL_BITS(CHANNEL_BITS)) u_front (
    .in_data (in_data),
    .cls     (cls)
  );

  hsvrgb_fifo #(.WIDTH($bits(hsvrgb_pkg::class_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (mid_pop),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  hsvrgb_back #(.CHANNEL_BITS(CHANNEL_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_item  (mid_item),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_item  (res_item)
  );

  hsvrgb_fifo #(.WIDTH($bits(hsvrgb_pkg::rgb_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (res_item),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

endmodule

### hdl/hsvrgb_fifo.sv
module hsvrgb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [AW:0]      wp_r;
  logic [AW:0]      rp_r;
  logic [WIDTH-1:0] mem_r [DEPTH];

  assign empty = (wp_r == rp_r);
  assign full  = (wp_r[AW] != rp_r[AW]) && (wp_r[AW-1:0] == rp_r[AW-1:0]);
  assign rdata = mem_r[rp_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (push && !full) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop && !empty) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r[AW-1:0]] <= wdata;
    end
  end

endmodule

### hdl/hsvrgb_front.sv
module hsvrgb_front #(
  parameter int CHANNEL_BITS = hsvrgb_pkg::CHANNEL_BITS_DEF
) (
  input  hsvrgb_pkg::hsv_t   in_data,
  output hsvrgb_pkg::class_t cls
);

  localparam int N = CHANNEL_BITS;

  logic [hsvrgb_pkg::HUE_W-1:0] hue_w;
  logic [hsvrgb_pkg::HUE_W-1:0] base;
  hsvrgb_pkg::sector_t          sector;

  always_comb begin
    // Anything at or past a full turn counts as hue zero.
    hue_w = (in_data.hue >= hsvrgb_pkg::HUE_TURN) ? '0 : in_data.hue;
    if (hue_w < hsvrgb_pkg::HUE_SECTOR) begin
      sector = hsvrgb_pkg::SEC_R_TO_Y;
      base   = '0;
    end else if (hue_w < hsvrgb_pkg::HUE_SECTOR * 15'd2) begin
      sector = hsvrgb_pkg::SEC_Y_TO_G;
      base   = hsvrgb_pkg::HUE_SECTOR;
    end else if (hue_w < hsvrgb_pkg::HUE_SECTOR * 15'd3) begin
      sector = hsvrgb_pkg::SEC_G_TO_C;
      base   = hsvrgb_pkg::HUE_SECTOR * 15'd2;
    end else if (hue_w < hsvrgb_pkg::HUE_SECTOR * 15'd4) begin
      sector = hsvrgb_pkg::SEC_C_TO_B;
      base   = hsvrgb_pkg::HUE_SECTOR * 15'd3;
    end else if (hue_w < hsvrgb_pkg::HUE_SECTOR * 15'd5) begin
      sector = hsvrgb_pkg::SEC_B_TO_M;
      base   = hsvrgb_pkg::HUE_SECTOR * 15'd4;
    end else begin
      sector = hsvrgb_pkg::SEC_M_TO_R;
      base   = hsvrgb_pkg::HUE_SECTOR * 15'd5;
    end
  end

  always_comb begin
    cls.sector = sector;
    cls.gray   = (N'(in_data.saturation) == '0);
    cls.rem    = hsvrgb_pkg::REM_W'(hue_w - base);
    cls.sat    = in_data.saturation;
    cls.val    = in_data.brightness;
  end

endmodule

### hdl/hsvrgb_div_max.sv
module hsvrgb_div_max #(
  parameter int N  = 8,
  parameter int XW = 16,
  parameter int QW = 8
) (
  input  logic [XW-1:0] x,
  output logic [QW-1:0] q
);

  // Quotient of x by 2^N - 1, for x up to (2^N - 1)^3. The estimate from two
  // shifted adds is low by at most two, and the remainder fixes it.
  localparam logic [N+1:0] CM  = (N+2)'((1 << N) - 1);
  localparam logic [N+1:0] CM2 = (N+2)'(2 * ((1 << N) - 1));

  logic [XW:0]  xs;
  logic [XW:0]  qa;
  logic [XW:0]  rm_w;
  logic [N+1:0] rm;
  logic [1:0]   corr;

  always_comb begin
    xs   = {1'b0, x} + (XW+1)'(x >> N);
    qa   = xs >> N;
    rm_w = {1'b0, x} - ((qa << N) - qa);
    rm   = rm_w[N+1:0];
    if (rm >= CM2) begin
      corr = 2'd2;
    end else if (rm >= CM) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
    q = QW'(qa + (XW+1)'(corr));
  end

endmodule

### hdl/hsvrgb_back.sv
module hsvrgb_back #(
  parameter int CHANNEL_BITS = hsvrgb_pkg::CHANNEL_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mid_empty,
  input  hsvrgb_pkg::class_t mid_item,
  output logic               mid_pop,
  input  logic               out_full,
  output logic               out_push,
  output hsvrgb_pkg::rgb_t   out_item
);

  localparam int N     = CHANNEL_BITS;
  localparam int NSTG  = 7;
  localparam int LAST  = NSTG - 1;
  localparam int YW    = N + 4;
  localparam int FK    = N + 4;
  localparam int RW    = hsvrgb_pkg::REM_W + N;
  localparam logic [N-1:0]   CH_MAX = {N{1'b1}};
  localparam logic [2*N-1:0] MM     = (2*N)'(CH_MAX) * (2*N)'(CH_MAX);
  localparam logic [FK-1:0]  FRECIP = FK'((2 ** FK) / hsvrgb_pkg::FRAC_DIV);

  typedef struct packed {
    hsvrgb_pkg::sector_t sector;
    logic                gray;
    logic [N-1:0]        sat;
    logic [N-1:0]        val;
    logic [N-1:0]        pv;
  } carry_t;

  logic [NSTG-1:0] vld_r;
  carry_t          car_r [NSTG];
  logic            adv;

  logic [YW-1:0]   y_r;
  logic [2*N-1:0]  vms_r;
  logic [2*YW-1:0] fprod_r;
  logic [YW-1:0]   y1_r;
  logic [N-1:0]    f_r;
  logic [2*N-1:0]  sf_r;
  logic [2*N-1:0]  smf_r;
  logic [3*N-1:0]  xq_r;
  logic [3*N-1:0]  xt_r;
  logic [2*N-1:0]  q1_r;
  logic [2*N-1:0]  t1_r;
  logic [N-1:0]    q_r;
  logic [N-1:0]    t_r;

  logic [N-1:0]    s_in;
  logic [N-1:0]    v_in;
  logic [RW-1:0]   rem_w;
  logic [RW-1:0]   frac_w;
  logic [YW-1:0]   y_in;
  logic [N-1:0]    pv_div;
  logic [N:0]      fqa;
  logic [YW-1:0]   fqa_w;
  logic [YW-1:0]   frm;
  logic [N-1:0]    f_in;
  logic [2*N-1:0]  q1_div;
  logic [2*N-1:0]  t1_div;
  logic [N-1:0]    q_div;
  logic [N-1:0]    t_div;
  logic [N-1:0]    r_sel;
  logic [N-1:0]    g_sel;
  logic [N-1:0]    b_sel;

  // The whole pipeline moves unless a finished pixel is stuck on a full queue.
  assign adv      = !(vld_r[LAST] && out_full);
  assign mid_pop  = adv && !mid_empty;
  assign out_push = vld_r[LAST] && !out_full;

  always_comb begin
    s_in   = N'(mid_item.sat);
    v_in   = N'(mid_item.val);
    rem_w  = RW'(mid_item.rem);
    frac_w = (rem_w << N) - rem_w;
    y_in   = YW'(frac_w >> hsvrgb_pkg::FRAC_SHIFT);
  end

  // The reciprocal estimate of y / 15 is low by at most one.
  always_comb begin
    fqa   = (N+1)'(fprod_r >> FK);
    fqa_w = YW'(fqa);
    frm   = y1_r - ((fqa_w << 4) - fqa_w);
    f_in  = N'(fqa + ((frm >= YW'(hsvrgb_pkg::FRAC_DIV)) ? (N+1)'(1) : (N+1)'(0)));
  end

  hsvrgb_div_max #(.N(N), .XW(2*N), .QW(N)) u_div_p (.x(vms_r), .q(pv_div));
  hsvrgb_div_max #(.N(N), .XW(3*N), .QW(2*N)) u_div_q1 (.x(xq_r), .q(q1_div));
  hsvrgb_div_max #(.N(N), .XW(3*N), .QW(2*N)) u_div_t1 (.x(xt_r), .q(t1_div));
  hsvrgb_div_max #(.N(N), .XW(2*N), .QW(N)) u_div_q2 (.x(q1_r), .q(q_div));
  hsvrgb_div_max #(.N(N), .XW(2*N), .QW(N)) u_div_t2 (.x(t1_r), .q(t_div));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], mid_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      car_r[0].sector <= mid_item.sector;
      car_r[0].gray   <= mid_item.gray;
      car_r[0].sat    <= s_in;
      car_r[0].val    <= v_in;
      car_r[0].pv     <= '0;
      y_r             <= y_in;
      vms_r           <= (2*N)'(v_in) * (2*N)'(CH_MAX - s_in);

      car_r[1].sector <= car_r[0].sector;
      car_r[1].gray   <= car_r[0].gray;
      car_r[1].sat    <= car_r[0].sat;
      car_r[1].val    <= car_r[0].val;
      car_r[1].pv     <= pv_div;
      fprod_r         <= (2*YW)'(y_r) * (2*YW)'(FRECIP);
      y1_r            <= y_r;

      car_r[2]        <= car_r[1];
      f_r             <= f_in;

      car_r[3]        <= car_r[2];
      sf_r            <= (2*N)'(car_r[2].sat) * (2*N)'(f_r);
      smf_r           <= (2*N)'(car_r[2].sat) * (2*N)'(CH_MAX - f_r);

      car_r[4]        <= car_r[3];
      xq_r            <= (3*N)'(car_r[3].val) * (3*N)'(MM - sf_r);
      xt_r            <= (3*N)'(car_r[3].val) * (3*N)'(MM - smf_r);

      car_r[5]        <= car_r[4];
      q1_r            <= q1_div;
      t1_r            <= t1_div;

      car_r[6]        <= car_r[5];
      q_r             <= q_div;
      t_r             <= t_div;
    end
  end

  always_comb begin
    if (car_r[LAST].gray) begin
      r_sel = car_r[LAST].val;
      g_sel = car_r[LAST].val;
      b_sel = car_r[LAST].val;
    end else begin
      case (car_r[LAST].sector)
        hsvrgb_pkg::SEC_R_TO_Y: begin
          r_sel = car_r[LAST].val;
          g_sel = t_r;
          b_sel = car_r[LAST].pv;
        end
        hsvrgb_pkg::SEC_Y_TO_G: begin
          r_sel = q_r;
          g_sel = car_r[LAST].val;
          b_sel = car_r[LAST].pv;
        end
        hsvrgb_pkg::SEC_G_TO_C: begin
          r_sel = car_r[LAST].pv;
          g_sel = car_r[LAST].val;
          b_sel = t_r;
        end
        hsvrgb_pkg::SEC_C_TO_B: begin
          r_sel = car_r[LAST].pv;
          g_sel = q_r;
          b_sel = car_r[LAST].val;
        end
        hsvrgb_pkg::SEC_B_TO_M: begin
          r_sel = t_r;
          g_sel = car_r[LAST].pv;
          b_sel = car_r[LAST].val;
        end
        default: begin
          r_sel = car_r[LAST].val;
          g_sel = car_r[LAST].pv;
          b_sel = q_r;
        end
      endcase
    end
    out_item.red   = hsvrgb_pkg::CH_W'(r_sel);
    out_item.green = hsvrgb_pkg::CH_W'(g_sel);
    out_item.blue  = hsvrgb_pkg::CH_W'(b_sel);
  end

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[LAST] && out_full) |=> vld_r[LAST])
    else $error("finished pixel lost while the result queue was full");

  a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_push && car_r[LAST].gray) |->
      (out_item.red == out_item.green && out_item.green == out_item.blue))
    else $error("gray pixel does not have equal channels");

  a_below_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> (q_r <= car_r[LAST].val && t_r <= car_r[LAST].val &&
                  car_r[LAST].pv <= car_r[LAST].val))
    else $error("p, q or t exceeds the value channel");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> (f_r <= CH_MAX))
    else $error("sector fraction out of range");
`endif

endmodule
